// File: sv/dcrb_pkg.sv
package dcrb_pkg;

  localparam logic [15:0] AddrLcd      = 16'h0014;
  localparam logic [15:0] AddrPoolLo   = 16'h001c;
  localparam logic [15:0] AddrPalLo    = 16'h0020;
  localparam logic [15:0] AddrPalHi    = 16'h003f;
  localparam logic [15:0] AddrTmrCtrl  = 16'h00a2;
  localparam logic [15:0] AddrFreqLo   = 16'h00a4;

  localparam logic [1:0] CfgGray    = 2'd0;
  localparam logic [1:0] CfgTwoBit  = 2'd1;
  localparam logic [1:0] CfgVariant = 2'd2;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [7:0] line;
    logic [15:0] hc;
    logic [15:0] vc;
    logic       mapped;
  } dcrb_req_t;

endpackage

// File: sv/dcrb_palette_mem.sv
module dcrb_palette_mem (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       we,
  input  logic [4:0] waddr,
  input  logic [7:0] wdata,
  input  logic       re,
  input  logic [4:0] raddr,
  output logic [7:0] rdata
);
  logic [5:0]  mem [32];
  logic [31:0] vld_r;
  logic [5:0]  q_r;
  logic        qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdata[6:4], wdata[2:0]};
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        qv_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = qv_r ? {1'b0, q_r[5:3], 1'b0, q_r[2:0]} : 8'd0;
endmodule

// File: sv/display_controller_register_bank.sv
// Register bank of a handheld display controller, one bus access per word. An accepted word
// is held in one stage while the registers and the palette memory are read, and its result
// word is then loaded into the output register once that register can advance. A new word
// is taken whenever the output register is empty or being taken, so with no output stall
// one word is accepted every cycle; an output stall stops the input in the same cycle. Writes
// take effect at the accepting edge, so each read sees every earlier write. Configuration
// writes are taken at once and should be made only while no word is in flight.
module display_controller_register_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_current_line,
  input  logic [15:0] in_htimer_count,
  input  logic [15:0] in_vtimer_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_htimer_clear,
  output logic        out_vtimer_clear,
  output logic        out_icons_changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import dcrb_pkg::*;

  logic gray_r, two_r, var_r;
  logic [5:0] de_r, sb_r, icon_r;
  logic [7:0] bc_r, lc_r, scnt_r, mb_r;
  logic [6:0] sf_r;
  logic [7:0] ws_r [12];
  logic [8:0] lcd_r;
  logic [7:0] ft_r [2];
  logic [7:0] pool_r [4];
  logic [3:0] tc_r;
  logic [15:0] fq_r [2];

  logic s1_v_r;
  dcrb_req_t s1_r;
  logic o_v_r;
  logic [7:0] o_rd_r;
  logic o_h_r, o_v2_r, o_i_r;

  logic adv, acc, s1_pal, pal_we, s1_has_out;
  logic [15:0] a;
  logic [7:0] d, pal_q, rd;
  logic hclr, vclr, icons;

  assign a = in_address;
  assign d = in_write_data;
  assign adv = !o_v_r || !out_stall;
  assign in_stall = !adv;
  assign acc = in_valid && adv;
  assign cfg_ready = 1'b1;

  assign pal_we = acc && in_cmd == CmdWrite && a >= AddrPalLo && a <= AddrPalHi;

  dcrb_palette_mem u_pal (
    .clk(clk), .rst_n(rst_n), .we(pal_we), .waddr(a[4:0]), .wdata(d),
    .re(acc), .raddr(a[4:0]), .rdata(pal_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_r <= 1'b1; two_r <= 1'b1; var_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgGray:    gray_r <= cfg_data[0];
        CfgTwoBit:  two_r  <= cfg_data[0];
        CfgVariant: var_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      de_r <= '0; bc_r <= '0; lc_r <= '0; sb_r <= '0; sf_r <= '0; scnt_r <= '0;
      mb_r <= '0; lcd_r <= '0; icon_r <= '0; tc_r <= '0;
      for (int i = 0; i < 12; i++) ws_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        ft_r[i] <= '0; fq_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) pool_r[i] <= '0;
    end else if (acc && in_cmd == CmdWrite && a[15:8] == 8'd0) begin
      if (a[7:0] >= 8'h08 && a[7:0] <= 8'h13) ws_r[4'(a[7:0] - 8'h08)] <= d;
      if (a >= AddrPoolLo && a <= 16'h001f) pool_r[a[1:0]] <= d;
      case (a[7:0])
        8'h00: de_r <= d[5:0];
        8'h01: bc_r <= d;
        8'h03: lc_r <= d;
        8'h04: sb_r <= d[5:0];
        8'h05: sf_r <= d[6:0];
        8'h06: scnt_r <= d;
        8'h07: mb_r <= d;
        AddrLcd[7:0]: begin
          if (var_r) lcd_r <= {d[1], d[7:4], lcd_r[3:1], d[0]};
          else lcd_r <= {lcd_r[8], d};
        end
        8'h15: icon_r <= d[5:0];
        8'h16: ft_r[0] <= d;
        8'h17: ft_r[1] <= d;
        AddrTmrCtrl[7:0]: tc_r <= d[3:0];
        8'ha4: begin fq_r[0][7:0] <= d; tc_r[1:0] <= 2'b11; end
        8'ha5: begin fq_r[0][15:8] <= d; tc_r[1:0] <= 2'b11; end
        8'ha6: begin fq_r[1][7:0] <= d; tc_r[3:2] <= 2'b11; end
        8'ha7: begin fq_r[1][15:8] <= d; tc_r[3:2] <= 2'b11; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
    end
    if (acc) begin
      s1_r.cmd <= in_cmd; s1_r.addr <= a[7:0]; s1_r.wdata <= d;
      s1_r.line <= in_current_line; s1_r.hc <= in_htimer_count;
      s1_r.vc <= in_vtimer_count; s1_r.mapped <= a[15:8] == 8'd0;
    end
  end

  assign s1_pal = s1_r.addr >= AddrPalLo[7:0] && s1_r.addr <= AddrPalHi[7:0];
  assign s1_has_out = s1_v_r;

  always_comb begin
    rd = 8'd0; hclr = 1'b0; vclr = 1'b0; icons = 1'b0;
    if (s1_r.mapped) begin
      if (s1_r.cmd == CmdRead) begin
        if (s1_r.addr >= 8'h08 && s1_r.addr <= 8'h13) rd = ws_r[4'(s1_r.addr - 8'h08)];
        else if (s1_r.addr >= AddrPoolLo[7:0] && s1_r.addr <= 8'h1f)
          rd = pool_r[s1_r.addr[1:0]];
        else if (s1_pal) rd = pal_q;
        else begin
          case (s1_r.addr)
            8'h00: rd = {2'b0, de_r};
            8'h01: rd = gray_r ? {5'b0, bc_r[2:0]} : bc_r;
            8'h02: rd = s1_r.line;
            8'h03: rd = lc_r;
            8'h04: rd = two_r ? {3'b0, sb_r[4:0]} : {2'b0, sb_r};
            8'h05: rd = {1'b0, sf_r};
            8'h06: rd = scnt_r;
            8'h07: rd = two_r ? (mb_r & 8'h77) : mb_r;
            AddrLcd[7:0]: rd = var_r ? {lcd_r[7:4], 2'b0, lcd_r[8], lcd_r[0]} : lcd_r[7:0];
            8'h15: rd = {2'b0, icon_r};
            8'h16: rd = ft_r[0];
            8'h17: rd = ft_r[1];
            AddrTmrCtrl[7:0]: rd = {4'b0, tc_r};
            AddrFreqLo[7:0]: rd = fq_r[0][7:0];
            8'ha5: rd = fq_r[0][15:8];
            8'ha6: rd = fq_r[1][7:0];
            8'ha7: rd = fq_r[1][15:8];
            8'ha8: rd = s1_r.hc[7:0];
            8'ha9: rd = s1_r.hc[15:8];
            8'haa: rd = s1_r.vc[7:0];
            8'hab: rd = s1_r.vc[15:8];
            default: rd = 8'd0;
          endcase
        end
      end else begin
        case (s1_r.addr)
          AddrTmrCtrl[7:0]: begin hclr = s1_r.wdata[0]; vclr = s1_r.wdata[2]; end
          8'ha4, 8'ha5: hclr = 1'b1;
          8'ha6, 8'ha7: vclr = 1'b1;
          8'h15: icons = 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Stage one reads state only after its own word has been applied, so each read sees
  // every earlier write; the palette read is registered on the accepting edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= s1_has_out;
    end
    if (adv && s1_has_out) begin
      o_rd_r <= rd; o_h_r <= hclr; o_v2_r <= vclr; o_i_r <= icons;
    end
  end

  assign out_valid = o_v_r;
  assign out_read_data = o_rd_r;
  assign out_htimer_clear = o_h_r;
  assign out_vtimer_clear = o_v2_r;
  assign out_icons_changed = o_i_r;

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("stall without full output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("output word lost");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !in_stall |=> out_valid) else $error("word dropped");
endmodule
